### hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define I2CMBS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in this cycle implies a consequence in the next cycle.
`define I2CMBS_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

### hdl/i2cmbs_pkg.sv
// Shared types and constants of the I2C master bit sequencer.
package i2cmbs_pkg;

	typedef enum logic [2:0] {
		OP_START = 3'd0,
		OP_STOP  = 3'd1,
		OP_SEND  = 3'd2,
		OP_RECV  = 3'd3,
		OP_SACK  = 3'd4,
		OP_RACK  = 3'd5
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       ack;
		logic [7:0] samples;
	} cmd_t;

	typedef struct packed {
		logic busy;
	} sts_t;

	localparam int QDEPTH = 2;
	localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic [7:0] MSB_MASK = 8'h80;

endpackage

### hdl/i2cmbs_front.sv
// Front end: accepts requests, drops unused codes and queues commands.
module i2cmbs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         operation,
	input  logic [7:0]         data_byte,
	input  logic               ack_value,
	input  logic [7:0]         line_samples,
	output i2cmbs_pkg::cmd_t   q_cmd,
	output logic               q_valid,
	input  logic               q_pop
);
	import i2cmbs_pkg::*;

	cmd_t           mem_q [QDEPTH];
	logic [QPW-1:0] wr_q;
	logic [QPW-1:0] rd_q;
	logic [QCW-1:0] cnt_q;
	logic           cmd_ok;
	logic           push;
	logic           pop;

	// Codes above receive acknowledge are accepted and then discarded.
	always_comb begin
		cmd_ok = operation inside {[OP_START:OP_RACK]};
	end

	assign in_stall = (cnt_q == QCW'(QDEPTH));
	assign push     = in_valid && !in_stall && cmd_ok;
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_cmd    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{op: op_t'(operation), data: data_byte, ack: ack_value,
				samples: line_samples};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hdl/i2cmbs_back.sv
// Back end: steps through the pin writes of one command into an output register.
module i2cmbs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  i2cmbs_pkg::cmd_t q_cmd,
	input  logic             q_valid,
	output logic             q_pop,
	output i2cmbs_pkg::sts_t sts,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             scl_level,
	output logic             sda_level,
	output logic [7:0]       read_value,
	output logic             read_valid,
	output logic             last
);
	import i2cmbs_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t     state_q;
	op_t        op_q;
	logic       ack_q;
	logic [7:0] shift_q;
	logic [2:0] bit_q;
	logic [1:0] phase_q;
	logic       scl_q;
	logic       sda_q;
	logic       out_valid_q;
	logic [7:0] read_value_q;
	logic       read_valid_q;
	logic       last_q;

	logic       emit;
	logic       nxt_scl;
	logic       nxt_sda;
	logic       nxt_last;
	logic       nxt_rv;
	logic [7:0] nxt_rval;
	logic [7:0] nxt_shift;
	logic [2:0] nxt_bit;
	logic [1:0] nxt_phase;

	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign emit     = (state_q == S_RUN) && (!out_valid_q || !out_stall);
	assign sts.busy = (state_q == S_RUN);

	// The pin write for the current step of the command.
	always_comb begin
		nxt_scl   = scl_q;
		nxt_sda   = sda_q;
		nxt_last  = 1'b0;
		nxt_rv    = 1'b0;
		nxt_rval  = '0;
		nxt_shift = shift_q;
		nxt_bit   = bit_q;
		nxt_phase = phase_q + 1'b1;
		case (op_q)
			OP_START: begin
				case (phase_q)
					2'd0:    nxt_sda = 1'b1;
					2'd1:    nxt_scl = 1'b1;
					2'd2:    nxt_sda = 1'b0;
					default: begin
						nxt_scl  = 1'b0;
						nxt_last = 1'b1;
					end
				endcase
			end
			OP_STOP: begin
				case (phase_q)
					2'd0:    nxt_sda = 1'b0;
					2'd1:    nxt_scl = 1'b1;
					default: begin
						nxt_sda  = 1'b1;
						nxt_last = 1'b1;
					end
				endcase
			end
			OP_SEND: begin
				case (phase_q)
					2'd0:    nxt_sda = |(shift_q & MSB_MASK);
					2'd1:    nxt_scl = 1'b1;
					default: begin
						nxt_scl   = 1'b0;
						nxt_shift = {shift_q[6:0], 1'b0};
						nxt_bit   = bit_q + 1'b1;
						nxt_phase = 2'd0;
						nxt_last  = (bit_q == 3'd7);
					end
				endcase
			end
			OP_RECV: begin
				// The sample register rotates once per bit, so after eight bits
				// it again holds the whole received byte.
				case (phase_q)
					2'd0:    nxt_sda = 1'b1;
					2'd1: begin
						nxt_scl   = 1'b1;
						nxt_shift = {shift_q[6:0], shift_q[7]};
					end
					default: begin
						nxt_scl   = 1'b0;
						nxt_bit   = bit_q + 1'b1;
						nxt_phase = 2'd1;
						nxt_last  = (bit_q == 3'd7);
						nxt_rv    = (bit_q == 3'd7);
						nxt_rval  = (bit_q == 3'd7) ? shift_q : 8'h00;
					end
				endcase
			end
			OP_SACK: begin
				case (phase_q)
					2'd0:    nxt_sda = ack_q;
					2'd1:    nxt_scl = 1'b1;
					default: begin
						nxt_scl  = 1'b0;
						nxt_last = 1'b1;
					end
				endcase
			end
			OP_RACK: begin
				case (phase_q)
					2'd0:    nxt_sda = 1'b1;
					2'd1:    nxt_scl = 1'b1;
					default: begin
						nxt_scl  = 1'b0;
						nxt_last = 1'b1;
						nxt_rv   = 1'b1;
						nxt_rval = {7'd0, |(shift_q & MSB_MASK)};
					end
				endcase
			end
			default: begin
				nxt_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q    <= q_cmd.op;
			ack_q   <= q_cmd.ack;
			shift_q <= (q_cmd.op == OP_SEND) ? q_cmd.data : q_cmd.samples;
		end else if (emit) begin
			shift_q <= nxt_shift;
		end
		if (emit) begin
			read_value_q <= nxt_rval;
			last_q       <= nxt_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			bit_q        <= '0;
			phase_q      <= '0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			out_valid_q  <= 1'b0;
			read_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_RUN;
						bit_q   <= '0;
						phase_q <= '0;
					end
				end
				S_RUN: begin
					if (emit) begin
						bit_q   <= nxt_bit;
						phase_q <= nxt_phase;
						if (nxt_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (emit) begin
				scl_q        <= nxt_scl;
				sda_q        <= nxt_sda;
				read_valid_q <= nxt_rv;
				out_valid_q  <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign scl_level  = scl_q;
	assign sda_level  = sda_q;
	assign read_value = read_value_q;
	assign read_valid = read_valid_q;
	assign last       = last_q;

endmodule

### hdl/i2c_master_bit_sequencer_unit.sv
// Top level of the I2C master bit sequencer: front end, command queue and pin sequencer.
//
// Usage: one request on the input channel is one bus command (start, stop, send byte,
// receive byte, send acknowledge, receive acknowledge). A request is taken when in_valid
// is high and in_stall is low. Codes six and seven are taken and discarded.
// The output channel gives one request per SCL/SDA pin write, with the level of both
// lines after the write; last marks the final write of a command, and read_valid with
// read_value carries the received byte or acknowledge bit on that final write.
// Command lengths: start 4, stop 3, send byte 24, receive byte 17, either acknowledge 3.
// After the edge that takes the command, the first write passes through the load into
// the sequencer and then the output register before it can be taken.
// After that the sequencer makes one write per cycle while the receiver does not stall,
// and between commands it returns to idle to load the next one. Its phase and bit
// counters step through the writes.
// A two-entry queue sits between front and back end, so new commands are taken while
// the current one is still being written out; in_stall rises only when the queue is full.
// When the receiver stalls, the output register holds its write and the sequencer
// pauses; the queue fills and then stalls the sender.
// Reset (arst_n low) empties the queue, drops any command in progress and sets both
// lines to released high.
`include "assert_macros.svh"

module i2c_master_bit_sequencer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] operation,
	input  logic [7:0] data_byte,
	input  logic       ack_value,
	input  logic [7:0] line_samples,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl_level,
	output logic       sda_level,
	output logic [7:0] read_value,
	output logic       read_valid,
	output logic       last
);
	import i2cmbs_pkg::*;

	cmd_t q_cmd;
	logic q_valid;
	logic q_pop;
	sts_t sts;

	// Front end classifies each request and queues the valid commands.
	i2cmbs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.data_byte    (data_byte),
		.ack_value    (ack_value),
		.line_samples (line_samples),
		.q_cmd        (q_cmd),
		.q_valid      (q_valid),
		.q_pop        (q_pop)
	);

	// Back end turns one queued command at a time into its series of pin writes.
	i2cmbs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_cmd      (q_cmd),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.scl_level  (scl_level),
		.sda_level  (sda_level),
		.read_value (read_value),
		.read_valid (read_valid),
		.last       (last)
	);

	// A received value only ever comes with the final write of a command.
	`I2CMBS_ASSERT_ALWAYS(a_read_on_last, !(out_valid && read_valid) || last, "read_valid without last")
	// Every command that ends with the clock high is a stop, which releases data too.
	`I2CMBS_ASSERT_ALWAYS(a_end_released, !(out_valid && last && scl_level) || sda_level, "command ended with SCL high and SDA low")
	// While a non-final write waits in the output register, the sequencer is still in its command.
	`I2CMBS_ASSERT_ALWAYS(a_busy_mid_cmd, !(out_valid && !last) || sts.busy, "sequencer idle mid command")
	// A stalled pin write stays on the output unchanged.
	`I2CMBS_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable({scl_level, sda_level, read_value, read_valid, last}), "stalled write changed")

endmodule
